/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker in lca_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted (active low).
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* rtl/core/lca_pkg.sv */
// Shared types, constants and helper functions for the life automaton.
// No dependencies.
package lca_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int MIN_SIZE    = 3;
    localparam int SIZE_W      = 7;
    localparam int LINE_IDX_W  = $clog2(MAX_WIDTH);
    localparam int FUNC_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int S_DATA_W    = ((LINE_IDX_W + MAX_HEIGHT + 7) / 8) * 8;
    localparam int M_DATA_W    = MAX_HEIGHT;

    typedef logic [MAX_HEIGHT-1:0]  t_line;
    typedef t_line [MAX_WIDTH-1:0]  t_grid;
    typedef logic [SIZE_W-1:0]      t_size;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_ADVANCE = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_WIDTH  = 1'b0,
        CFG_ACTIVE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Saturate a size register into MIN_SIZE..hi.
    function automatic t_size clamp_size(input t_size v, input int hi);
        t_size r;
        if (v < SIZE_W'(MIN_SIZE))  r = SIZE_W'(MIN_SIZE);
        else if (v > SIZE_W'(hi))   r = SIZE_W'(hi);
        else                        r = v;
        return r;
    endfunction

    function automatic logic [3:0] count8(input logic [7:0] b);
        logic [3:0] s;
        s = '0;
        for (int k = 0; k < 8; k++) s = s + 4'(b[k]);
        return s;
    endfunction

    // B3/S23
    function automatic logic life_rule(input logic [3:0] n, input logic alive);
        return (n == 4'd3) || ((n == 4'd2) && alive);
    endfunction

endpackage

/* rtl/core/lca_gen.sv */
// Next-generation logic for the whole grid, toroidal wrap at the active sizes.
// Depends on lca_pkg.
module lca_gen
    import lca_pkg::*;
(
    input  t_grid i_grid,
    input  t_size i_width,
    input  t_size i_height,
    output t_grid o_grid
);

    logic [LINE_IDX_W-1:0] w_last_line;
    logic [LINE_IDX_W-1:0] w_last_cell;
    t_line                 w_hmask;

    assign w_last_line = LINE_IDX_W'(i_width - SIZE_W'(1));
    assign w_last_cell = LINE_IDX_W'(i_height - SIZE_W'(1));

    always_comb begin
        for (int j = 0; j < MAX_HEIGHT; j++) begin
            w_hmask[j] = SIZE_W'(j) < i_height;
        end
    end

    for (genvar gi = 0; gi < MAX_WIDTH; gi++) begin : g_line
        t_line w_up, w_mid, w_dn;
        t_line w_up_m, w_up_p, w_mid_m, w_mid_p, w_dn_m, w_dn_p;
        t_line w_next;
        logic  w_line_on;

        assign w_line_on = SIZE_W'(gi) < i_width;
        assign w_mid     = i_grid[gi];
        if (gi == 0) begin : g_up_wrap
            assign w_up = i_grid[w_last_line];
        end else begin : g_up
            assign w_up = i_grid[gi-1];
        end
        if (gi == MAX_WIDTH - 1) begin : g_dn_last
            assign w_dn = i_grid[0];
        end else begin : g_dn
            assign w_dn = (SIZE_W'(gi + 1) == i_width) ? i_grid[0] : i_grid[gi+1];
        end

        // Shifted copies: _m holds the cell at j-1, _p the cell at j+1, wrapped.
        always_comb begin
            w_up_m[0]  = w_up[w_last_cell];
            w_mid_m[0] = w_mid[w_last_cell];
            w_dn_m[0]  = w_dn[w_last_cell];
            for (int j = 1; j < MAX_HEIGHT; j++) begin
                w_up_m[j]  = w_up[j-1];
                w_mid_m[j] = w_mid[j-1];
                w_dn_m[j]  = w_dn[j-1];
            end
            for (int j = 0; j < MAX_HEIGHT - 1; j++) begin
                w_up_p[j]  = (LINE_IDX_W'(j) == w_last_cell) ? w_up[0]  : w_up[j+1];
                w_mid_p[j] = (LINE_IDX_W'(j) == w_last_cell) ? w_mid[0] : w_mid[j+1];
                w_dn_p[j]  = (LINE_IDX_W'(j) == w_last_cell) ? w_dn[0]  : w_dn[j+1];
            end
            w_up_p[MAX_HEIGHT-1]  = w_up[0];
            w_mid_p[MAX_HEIGHT-1] = w_mid[0];
            w_dn_p[MAX_HEIGHT-1]  = w_dn[0];
            for (int j = 0; j < MAX_HEIGHT; j++) begin
                w_next[j] = life_rule(count8({w_up_m[j], w_up[j], w_up_p[j],
                                              w_mid_m[j], w_mid_p[j],
                                              w_dn_m[j], w_dn[j], w_dn_p[j]}),
                                      w_mid[j]);
            end
        end

        assign o_grid[gi] = w_line_on ? (w_next & w_hmask) : '0;
    end

endmodule

/* rtl/core/life_cellular_automaton_top.sv */
// A result passes through the input register and then the result register.
// Throughput: one item per cycle for write, read and generation steps while the
// input is not stalled; a generation updates all 64x64 grid cells at once from lca_gen.
// Input and result registers decouple the stream sides; the input stalls only
// while both hold an item and the result side is not ready.
// Reset (sync, active low): grid cleared to zero, sizes 64, both stages empty.
module life_cellular_automaton_top
    import lca_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SIZE_W-1:0]     i_cfg_data,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,   // [5:0] line_index, [69:6] line_bits, rest 0
    input  logic [FUNC_W-1:0]     i_s_tuser,   // [1:0] func
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_DATA_W-1:0]   o_m_tdata,   // [63:0] read_bits
    output logic                  o_m_tuser    // [0] index_error
);

    t_size                 r_width, r_height;
    logic                  r_in_valid;
    logic [FUNC_W-1:0]     r_in_func;
    logic [LINE_IDX_W-1:0] r_in_idx;
    t_line                 r_in_bits;
    logic                  r_out_valid;
    t_line                 r_out_data;
    logic                  r_out_err;
    t_grid                 r_grid;
    t_grid                 n_grid;
    t_line                 n_read;
    logic                  n_err;

    t_size  w_width, w_height;
    t_line  w_hmask;
    t_grid  w_gen_grid;
    logic   w_out_free;
    logic   w_go;
    logic   w_line_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(MAX_WIDTH);
            r_height <= SIZE_W'(MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ACTIVE_WIDTH:  r_width  <= i_cfg_data;
                CFG_ACTIVE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_width  = clamp_size(r_width, MAX_WIDTH);
    assign w_height = clamp_size(r_height, MAX_HEIGHT);

    always_comb begin
        for (int j = 0; j < MAX_HEIGHT; j++) begin
            w_hmask[j] = SIZE_W'(j) < w_height;
        end
    end

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_go       = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_func <= i_s_tuser;
            r_in_idx  <= i_s_tdata[LINE_IDX_W-1:0];
            r_in_bits <= i_s_tdata[LINE_IDX_W +: MAX_HEIGHT];
        end
    end

    lca_gen u_gen (
        .i_grid   (r_grid),
        .i_width  (w_width),
        .i_height (w_height),
        .o_grid   (w_gen_grid)
    );

    assign w_line_op = (t_func'(r_in_func) == FUNC_WRITE) || (t_func'(r_in_func) == FUNC_READ);

    always_comb begin
        n_grid = r_grid;
        n_read = '0;
        n_err  = w_line_op && ({1'b0, r_in_idx} >= w_width);
        case (t_func'(r_in_func))
            FUNC_WRITE: begin
                if (!n_err) n_grid[r_in_idx] = r_in_bits & w_hmask;
            end
            FUNC_READ: begin
                if (!n_err) n_read = r_grid[r_in_idx] & w_hmask;
            end
            FUNC_ADVANCE: begin
                n_grid = w_gen_grid;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= '0;
        end else if (w_go) begin
            r_grid <= n_grid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_data <= n_read;
            r_out_err  <= n_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_err;

endmodule

/* rtl/core/lca_checker.sv */
// Port-level checker for life_cellular_automaton_top, bound to the top level.
// Depends on lca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lca_checker
    import lca_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,
    input logic                o_m_tuser
);

    `ASSERT_CLK(a_empty_after_reset, i_clk, !i_rst_n |=> !o_m_tvalid)
    `ASSERT_CLK_RST(a_err_zero_data, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
    `ASSERT_CLK_RST(a_stall_only_when_full, i_clk, i_rst_n, !o_s_tready |-> (o_m_tvalid && !i_m_tready))
    `ASSERT_CLK_RST(a_result_held, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
    `ASSERT_CLK_RST(a_idle_takes_input, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready)

endmodule

bind life_cellular_automaton_top lca_checker u_lca_checker (.*);
